>>> hw/rtl/utf8d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned PendW = 2;

  // lead byte patterns, compared under their masks
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code = 8'hF0;
  localparam logic [1:0]       ContTag   = 2'b10;

  // continuation bytes still expected after each lead
  localparam logic [PendW-1:0] PendNone = 2'd0;
  localparam logic [PendW-1:0] PendOne  = 2'd1;
  localparam logic [PendW-1:0] PendTwo  = 2'd2;
  localparam logic [PendW-1:0] PendThree = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           malformed;
    logic           text_done;
  } out_beat_t;

  // what one byte step hands to the output side
  typedef struct packed {
    logic      fire;
    out_beat_t beat;
  } step_res_t;

endpackage : utf8d_pkg
`default_nettype wire

>>> hw/rtl/utf8_stream_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Streaming UTF-8 decoder: one text byte per beat in, code points out.
// ----------------------------------------------------------------------------
//   channel  direction  payload     handshake
//   in       input      in_beat_t   in_valid / in_ready
//   out      output     out_beat_t  out_valid / out_ready
//
// one byte per cycle while results are not held; a byte is taken into the input
// register, decoded, and its result is written to the result register.
// the decode step sits combinationally between the two registers.
// reset clears both registers' valid flags and the sequence state.
// a held result stalls the input register only when its byte also produces
// a result; bytes that only open or extend a sequence keep flowing.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit
  import utf8d_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);

  logic      in_held;
  in_beat_t  in_q;
  logic      advance;
  logic      out_valid_next;
  step_res_t step;

  utf8d_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .beat    (in_q),
    .result  (step)
  );

  assign advance  = in_held && (!step.fire || !out_valid || out_ready);
  assign in_ready = !in_held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  assign out_valid_next = (out_valid && !out_ready) || (advance && step.fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.fire) begin
      out_data <= step.beat;
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !in_held && !out_valid)
    else $error("pipeline not empty after reset");

  a_input_holds: assert property (@(posedge clk) disable iff (rst)
    in_held && !advance |=> in_held && $stable(in_q))
    else $error("stalled input beat lost or changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    advance && step.fire |-> !out_valid || out_ready)
    else $error("result register overwritten while full");
`endif

endmodule : utf8_stream_decoder_unit
`default_nettype wire

>>> hw/rtl/utf8d_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_core
// Sequence state and the per-byte decode step; state moves on advance.
// ----------------------------------------------------------------------------
module utf8d_core
  import utf8d_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      advance,
  input  wire in_beat_t  beat,
  output step_res_t      result
);

  logic [CpW-1:0]   partial_value;
  logic [CpW-1:0]   partial_value_next;
  logic [PendW-1:0] bytes_pending;
  logic [PendW-1:0] bytes_pending_next;
  logic [CpW-1:0]   shifted;
  logic [ByteW-1:0] b;
  logic             done;

  assign b       = beat.text_byte;
  assign done    = beat.end_of_text;
  assign shifted = {partial_value[CpW-7:0], b[5:0]};

  always_comb begin
    partial_value_next = partial_value;
    bytes_pending_next = bytes_pending;
    result.fire = 1'b0;
    result.beat.code_point = '0;
    result.beat.malformed  = 1'b0;
    result.beat.text_done  = done;

    if (bytes_pending == PendNone) begin
      if (!b[7]) begin
        result.fire = 1'b1;
        result.beat.code_point = {{(CpW-ByteW){1'b0}}, b};
      end else if ((b & Lead2Mask) == Lead2Code) begin
        partial_value_next = {{(CpW-5){1'b0}}, b[4:0]};
        bytes_pending_next = PendOne;
      end else if ((b & Lead3Mask) == Lead3Code) begin
        partial_value_next = {{(CpW-4){1'b0}}, b[3:0]};
        bytes_pending_next = PendTwo;
      end else if ((b & Lead4Mask) == Lead4Code) begin
        partial_value_next = {{(CpW-3){1'b0}}, b[2:0]};
        bytes_pending_next = PendThree;
      end else begin
        result.fire = 1'b1;
        result.beat.malformed = 1'b1;
      end
      // lead byte flagged as last: cut off
      if (b[7] && !result.fire && done) begin
        result.fire = 1'b1;
        result.beat.malformed = 1'b1;
      end
    end else if (b[7:6] != ContTag) begin
      result.fire = 1'b1;
      result.beat.malformed = 1'b1;
    end else begin
      partial_value_next = shifted;
      bytes_pending_next = bytes_pending - PendOne;
      if (bytes_pending == PendOne) begin
        result.fire = 1'b1;
        result.beat.code_point = shifted;
      end else if (done) begin
        result.fire = 1'b1;
        result.beat.malformed = 1'b1;
      end
    end

    // any result leaves the decoder idle
    if (result.fire) begin
      partial_value_next = '0;
      bytes_pending_next = PendNone;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value <= '0;
      bytes_pending <= PendNone;
    end else if (advance) begin
      partial_value <= partial_value_next;
      bytes_pending <= bytes_pending_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    advance && result.fire |=> bytes_pending == PendNone && partial_value == '0)
    else $error("decoder state not idle after a result");

  a_malformed_zero: assert property (@(posedge clk) disable iff (rst)
    result.fire && result.beat.malformed |-> result.beat.code_point == '0)
    else $error("malformed result carries a code point");

  a_partial_bound: assert property (@(posedge clk) disable iff (rst)
    (bytes_pending != PendThree || partial_value[CpW-1:3] == '0) &&
    (bytes_pending != PendTwo   || partial_value[CpW-1:10] == '0) &&
    (bytes_pending != PendOne   || partial_value[CpW-1:16] == '0))
    else $error("partial value wider than the pending count allows");
`endif

endmodule : utf8d_core
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 stream decoder. Text bytes are sent over
// the input channel with random gaps, and each byte is run through a local
// decoder model. Every code point or malformed beat that leaves the block is
// compared field by field with the oldest predicted beat.
// ----------------------------------------------------------------------------
module tb_top;
  import utf8d_pkg::*;

  // payload bits kept from each lead byte and from continuation bytes
  localparam logic [ByteW-1:0] Lead2Bits = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Bits = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Bits = 8'h07;
  localparam logic [ByteW-1:0] ContBits  = 8'h3F;
  localparam logic [ByteW-1:0] ContCode  = 8'h80;
  localparam int unsigned      RandItems = 1200;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  // decoder model state
  logic [CpW-1:0]   dec_part = '0;
  logic [PendW-1:0] dec_pend = PendNone;

  out_beat_t cp_expect_q[$];
  int unsigned err_cnt   = 0;
  int unsigned sent_cnt  = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  int unsigned hold_req  = 0;

  utf8_stream_decoder_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  initial begin
    #4ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // advances the model by one byte; returns 1 when the byte yields a beat
  function automatic bit decode_step(input in_beat_t beat, output out_beat_t res);
    logic [ByteW-1:0] b;
    bit               fire;
    b    = beat.text_byte;
    fire = 1'b0;
    res  = '0;
    if (dec_pend == PendNone) begin
      if (!b[ByteW-1]) begin
        fire = 1'b1;
        res.code_point = CpW'(b);
      end else if ((b & Lead2Mask) == Lead2Code) begin
        dec_part = CpW'(b & Lead2Bits);
        dec_pend = PendOne;
      end else if ((b & Lead3Mask) == Lead3Code) begin
        dec_part = CpW'(b & Lead3Bits);
        dec_pend = PendTwo;
      end else if ((b & Lead4Mask) == Lead4Code) begin
        dec_part = CpW'(b & Lead4Bits);
        dec_pend = PendThree;
      end else begin
        fire = 1'b1;
        res.malformed = 1'b1;
      end
      // a lead byte on the last byte of the text is a cut-off sequence
      if (!fire && beat.end_of_text) begin
        fire = 1'b1;
        res.malformed = 1'b1;
      end
    end else if (b[7:6] != ContTag) begin
      fire = 1'b1;
      res.malformed = 1'b1;
    end else begin
      dec_part = {dec_part[CpW-7:0], b[5:0]};
      dec_pend = dec_pend - 1'b1;
      if (dec_pend == PendNone) begin
        fire = 1'b1;
        res.code_point = dec_part;
      end else if (beat.end_of_text) begin
        fire = 1'b1;
        res.malformed = 1'b1;
      end
    end
    if (fire) begin
      res.text_done = beat.end_of_text;
      dec_part = '0;
      dec_pend = PendNone;
    end
    return fire;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // one byte beat; leaves valid high when no gap follows
  task automatic send_byte(input logic [ByteW-1:0] b, input bit eot);
    in_beat_t  beat;
    out_beat_t res;
    int unsigned gap;
    beat.text_byte   = b;
    beat.end_of_text = eot;
    in_data  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (decode_step(beat, res)) begin
      cp_expect_q.push_back(res);
    end
    sent_cnt++;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input logic [ByteW-1:0] seq[$], input bit eot_last);
    foreach (seq[i]) begin
      send_byte(seq[i], eot_last && (i == seq.size() - 1));
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (cp_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [ByteW-1:0] rand_cont();
    return ContCode | ByteW'($urandom_range(0, 63));
  endfunction

  function automatic logic [ByteW-1:0] rand_lead(input int unsigned len);
    case (len)
      2: begin
        return Lead2Code | ByteW'($urandom_range(0, 31));
      end
      3: begin
        return Lead3Code | ByteW'($urandom_range(0, 15));
      end
      4: begin
        return Lead4Code | ByteW'($urandom_range(0, 7));
      end
      default: begin
        return ByteW'($urandom_range(0, 127));
      end
    endcase
  endfunction

  // any byte that is not a continuation byte
  function automatic logic [ByteW-1:0] rand_non_cont();
    logic [ByteW-1:0] b;
    b = ByteW'($urandom_range(0, 255));
    if (b[7:6] == ContTag) begin
      b[6] = 1'b1;
    end
    return b;
  endfunction

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    int unsigned hold_left;
    int unsigned wait_left;
    hold_left = 0;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (wait_left > 0) begin
        out_ready <= 1'b0;
        wait_left--;
      end else if (rx_gaps_on && $urandom_range(0, 99) < 20) begin
        out_ready <= 1'b0;
        wait_left = pick_gap();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (cp_expect_q.size() == 0) begin
        report_mismatch("unexpected beat", 32'(out_data), 0);
      end else begin
        want = cp_expect_q.pop_front();
        if (out_data.code_point != want.code_point) begin
          report_mismatch("code_point", 32'(out_data.code_point), 32'(want.code_point));
        end
        if (out_data.malformed != want.malformed) begin
          report_mismatch("malformed", 32'(out_data.malformed), 32'(want.malformed));
        end
        if (out_data.text_done != want.text_done) begin
          report_mismatch("text_done", 32'(out_data.text_done), 32'(want.text_done));
        end
      end
    end
  end

  task automatic test_directed();
    send_text('{8'h00}, 1'b0);                      // nul
    send_text('{8'h7F}, 1'b0);
    send_text('{8'hC2, 8'h80}, 1'b0);
    send_text('{8'hDF, 8'hBF}, 1'b0);
    send_text('{8'hE0, 8'h80, 8'h80}, 1'b0);        // overlong passes
    send_text('{8'hED, 8'hA0, 8'h80}, 1'b0);        // surrogate passes
    send_text('{8'hF0, 8'h90, 8'h80, 8'h80}, 1'b0);
    send_text('{8'hF7, 8'hBF, 8'hBF, 8'hBF}, 1'b0); // largest value
    send_text('{8'h80}, 1'b0);                      // bad leads
    send_text('{8'hBF}, 1'b0);
    send_text('{8'hF8}, 1'b0);
    send_text('{8'hFF}, 1'b0);
    send_text('{8'hC3, 8'h41}, 1'b0);               // broken, 0x41 consumed
    send_text('{8'hE2, 8'h82}, 1'b1);               // cut off by end flag
    send_text('{8'hC3}, 1'b1);
    send_text('{8'h41}, 1'b1);
    send_text('{8'hE2, 8'h82, 8'hAC}, 1'b1);
    send_text('{8'hFF}, 1'b1);
    wait_drain();
  endtask

  // receiver held off while bytes keep coming, so the block backs up
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    hold_req   = 300;
    repeat (60) begin
      send_byte(rand_lead(1), 1'($urandom_range(0, 1)));
    end
    send_text('{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC}, 1'b0);
    wait_drain();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random();
    logic [ByteW-1:0] seq[$];
    int unsigned r;
    int unsigned len;
    int unsigned cut;
    int unsigned start;
    bit          eot;
    start = sent_cnt;
    while (sent_cnt - start < RandItems) begin
      if ((sent_cnt - start) % 150 < 6) begin
        tx_gaps_on = $urandom_range(0, 3) != 0;
        rx_gaps_on = $urandom_range(0, 3) != 0;
      end
      if ((sent_cnt - start) % 300 < 6 && sent_cnt != start) begin
        wait_drain();
      end
      seq.delete();
      r   = $urandom_range(0, 99);
      eot = $urandom_range(0, 99) < 8;
      if (r < 80) begin
        // well-formed sequence
        len = (r < 30) ? 1 : (r < 50) ? 2 : (r < 65) ? 3 : 4;
        seq.push_back(rand_lead(len));
        repeat (len - 1) seq.push_back(rand_cont());
      end else if (r < 88) begin
        seq.push_back(ByteW'($urandom_range(0, 255)));
        eot = 1'($urandom_range(0, 1));
      end else if (r < 94) begin
        // non-continuation byte inside a sequence
        len = $urandom_range(2, 4);
        cut = $urandom_range(0, len - 2);
        seq.push_back(rand_lead(len));
        repeat (cut) seq.push_back(rand_cont());
        seq.push_back(rand_non_cont());
      end else begin
        // sequence cut off by the end flag
        len = $urandom_range(2, 4);
        cut = $urandom_range(0, len - 2);
        seq.push_back(rand_lead(len));
        repeat (cut) seq.push_back(rand_cont());
        eot = 1'b1;
      end
      send_text(seq, eot);
    end
    wait_drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
